/* sv/lhb_pkg.sv */
package lhb_pkg;

  localparam int NumBins = 256;
  localparam int BinW    = 8;
  localparam int CountW  = 32;
  localparam int HeightW = 9;
  localparam int LumaW   = 24;
  localparam int ProdW   = 2 * CountW;

  localparam logic [LumaW-1:0]   LumaWr     = 24'd19595;
  localparam logic [LumaW-1:0]   LumaWg     = 24'd38470;
  localparam logic [LumaW-1:0]   LumaWb     = 24'd7471;
  localparam logic [HeightW-1:0] BarMax     = 9'd256;
  localparam logic [CountW-1:0]  ScaleReset = 32'd2071;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [BinW-1:0] bin;
    logic [BinW-1:0] row;
  } cmd_t;

endpackage

/* sv/lhb_front.sv */
module lhb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    operation_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [lhb_pkg::BinW-1:0]      bin_index_i,
  input  logic [lhb_pkg::BinW-1:0]      row_i,
  output logic                          cmd_valid_o,
  output lhb_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_pop_i
);

  logic [lhb_pkg::LumaW-1:0] luma_acc;
  lhb_pkg::op_e              op;
  lhb_pkg::cmd_t             cmd_in;
  lhb_pkg::cmd_t             queue_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                cnt_q, cnt_d;
  logic                      enq;

  // bt.601 luma in q8.16 from q0.16 weights, weights sum to one so no clamp
  assign luma_acc = lhb_pkg::LumaWr * lhb_pkg::LumaW'(red_i)
                  + lhb_pkg::LumaWg * lhb_pkg::LumaW'(green_i)
                  + lhb_pkg::LumaWb * lhb_pkg::LumaW'(blue_i);

  assign op = lhb_pkg::op_e'(operation_i);

  always_comb begin
    cmd_in.op  = op;
    cmd_in.row = row_i;
    cmd_in.bin = (op == lhb_pkg::OP_COUNT) ? luma_acc[23:16] : bin_index_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // unused code is taken and dropped
  assign enq = push && !full && (op != lhb_pkg::OP_NONE);

  always_comb begin
    case ({enq, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* sv/lhb_back.sv */
module lhb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  lhb_pkg::cmd_t                  cmd_i,
  output logic                           cmd_pop_o,
  input  logic [lhb_pkg::CountW-1:0]     bar_scale_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [lhb_pkg::HeightW-1:0]    bar_height_o,
  output logic                           pixel_lit_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  typedef struct packed {
    logic [lhb_pkg::HeightW-1:0] height;
    logic                        lit;
  } res_t;

  state_e                          state_q, state_d;
  lhb_pkg::op_e                    op_q;
  logic [lhb_pkg::BinW-1:0]        bin_q;
  logic [lhb_pkg::BinW-1:0]        row_q;

  logic [lhb_pkg::CountW-1:0]      mem [lhb_pkg::NumBins];
  logic [lhb_pkg::NumBins-1:0]     vld_q;
  logic [lhb_pkg::CountW-1:0]      rd_data_q;
  logic                            rd_vld_q;
  logic [lhb_pkg::CountW-1:0]      count;
  logic                            mem_we;
  logic                            clr_we;

  logic [lhb_pkg::ProdW-1:0]       prod_d, prod_q;
  logic                            sat;
  logic [lhb_pkg::HeightW-1:0]     height;
  res_t                            res;

  res_t                            out_q [2];
  logic                            owr_q, ord_q;
  logic [1:0]                      ocnt_q;
  logic                            ofull, opush, opop;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign clr_we    = cmd_pop_o && (cmd_i.op == lhb_pkg::OP_CLEAR);
  assign mem_we    = (state_q == ST_READ) && (op_q == lhb_pkg::OP_COUNT);

  // a bin never written since reset or clear reads as zero
  assign count  = rd_vld_q ? rd_data_q : '0;
  assign prod_d = count * bar_scale_i;

  assign sat    = (|prod_q[lhb_pkg::ProdW-1:25]) || (prod_q[24:16] > lhb_pkg::BarMax);
  assign height = sat ? lhb_pkg::BarMax : prod_q[24:16];
  assign res.height = height;
  assign res.lit    = ({1'b0, row_q} < height);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op != lhb_pkg::OP_CLEAR)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = (op_q == lhb_pkg::OP_DRAW) ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!ofull) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clr_we) begin
        vld_q[cmd_i.bin] <= 1'b0;
      end
      if (mem_we) begin
        vld_q[bin_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      op_q      <= cmd_i.op;
      bin_q     <= cmd_i.bin;
      row_q     <= cmd_i.row;
      rd_data_q <= mem[cmd_i.bin];
      rd_vld_q  <= vld_q[cmd_i.bin];
    end
    if (mem_we) begin
      mem[bin_q] <= count + lhb_pkg::CountW'(1);
    end
    if (state_q == ST_READ) begin
      prod_q <= prod_d;
    end
  end

  // result queue
  assign ofull        = (ocnt_q == 2'd2);
  assign empty        = (ocnt_q == 2'd0);
  assign opush        = (state_q == ST_OUT) && !ofull;
  assign opop         = pop && !empty;
  assign bar_height_o = out_q[ord_q].height;
  assign pixel_lit_o  = out_q[ord_q].lit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) begin
        owr_q <= !owr_q;
      end
      if (opop) begin
        ord_q <= !ord_q;
      end
      case ({opush, opop})
        2'b10:   ocnt_q <= ocnt_q + 2'd1;
        2'b01:   ocnt_q <= ocnt_q - 2'd1;
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      out_q[owr_q] <= res;
    end
  end

endmodule

/* sv/luma_histogram_bar_engine.sv */
// luminance histogram with bar readout, 256 bins of 32-bit wrapping counts
// input channel: push/full, one transaction per item; operation selects
//   clear bin (bin_index_i), count pixel (red/green/blue) or draw (bin_index_i, row_i)
// result channel: empty/pop, one transaction per draw carrying bar_height_o and
//   pixel_lit_o; clear, count and the unused code give no result
// bar_scale_i is loaded on bar_scale_we_i; write it only while the engine is idle
// the front computes luma and queues up to two commands; the back is a sequencer
//   around the bin memory: one read port, one write port, registered read data
// the sequencer takes a command only in idle, finishing each item before the next;
//   clear stays in idle, count adds read (read-modify-write), draw adds read (scale
//   multiply) and out, then its result passes through the two-entry result queue
// reset clears all bin valid flags at once, so every bin reads zero with no sweep;
//   the scale returns to 2071
// a stalled result side fills the two-entry result queue, then the sequencer holds
//   and the command queue fills and raises full
module luma_histogram_bar_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     operation_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  input  logic [lhb_pkg::BinW-1:0]       bin_index_i,
  input  logic [lhb_pkg::BinW-1:0]       row_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [lhb_pkg::HeightW-1:0]    bar_height_o,
  output logic                           pixel_lit_o,
  input  logic                           bar_scale_we_i,
  input  logic [lhb_pkg::CountW-1:0]     bar_scale_i
);

  logic [lhb_pkg::CountW-1:0] bar_scale_q;
  logic                       cmd_valid;
  lhb_pkg::cmd_t              cmd;
  logic                       cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_scale_q <= lhb_pkg::ScaleReset;
    end else if (bar_scale_we_i) begin
      bar_scale_q <= bar_scale_i;
    end
  end

  lhb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .bin_index_i (bin_index_i),
    .row_i       (row_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lhb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .bar_scale_i  (bar_scale_q),
    .empty        (empty),
    .pop          (pop),
    .bar_height_o (bar_height_o),
    .pixel_lit_o  (pixel_lit_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (bar_height_o <= lhb_pkg::BarMax))
    else $error("bar height above saturation limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pixel_lit_o) |-> (bar_height_o != '0))
    else $error("pixel lit under an empty bar");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("command queue full but nothing offered to the sequencer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !cmd_pop || $past(cmd.op) == lhb_pkg::OP_CLEAR)
    else $error("sequencer took a command while a read was in flight");

endmodule
